[sv/spms_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stride pattern mode selector.
package spms_pkg;

  localparam int ADDRESS_BITS_DEF = 48;
  localparam int COUNTER_BITS_DEF = 16;

  localparam int SHIFT_BITS      = 4;
  localparam int WINDOW_BITS     = 16;
  localparam int MODE_BITS       = 2;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 16;
  localparam int OUT_TDATA_BITS  = 8;
  localparam int OUT_CHANGED_BIT = 2;
  localparam int NUM_CLASSES     = 6;

  localparam logic [SHIFT_BITS-1:0]  LINE_SIZE_LOG2_RESET = 4'd6;
  localparam logic [WINDOW_BITS-1:0] WINDOW_LENGTH_RESET  = 16'd256;

  // Ratio test: RATIO_DEN * count > RATIO_NUM * total, i.e. count over 0.6 of total
  localparam int RATIO_NUM = 3;
  localparam int RATIO_DEN = 5;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_DISABLED = 2'd0,
    MODE_STRIDE   = 2'd1,
    MODE_TAGGED   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CL_SAME   = 3'd0,
    CL_NEXT   = 3'd1,
    CL_STREAM = 3'd2,
    CL_BACK   = 3'd3,
    CL_FIXED  = 3'd4,
    CL_RANDOM = 3'd5
  } class_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LINE_SIZE_LOG2 = 1'b0,
    REG_WINDOW_LENGTH  = 1'b1
  } reg_index_t;

  typedef struct packed {
    class_t cls;
    logic   neg;
  } class_info_t;

endpackage

[sv/spms_classify.sv]
`timescale 1ns / 1ps
// Access classifier: stride against the previous read line and its class.
module spms_classify #(
  parameter int ADDRESS_BITS = spms_pkg::ADDRESS_BITS_DEF
) (
  input  logic [ADDRESS_BITS-1:0] line,
  input  logic [ADDRESS_BITS-1:0] prev_line,
  input  logic                    prev_neg,
  input  logic [ADDRESS_BITS-1:0] prev_abs,
  input  logic                    history_valid,
  output spms_pkg::class_info_t   info,
  output logic [ADDRESS_BITS-1:0] mag
);
  import spms_pkg::*;

  logic                    neg_raw;
  logic [ADDRESS_BITS-1:0] diff_up;
  logic [ADDRESS_BITS-1:0] diff_dn;
  logic [ADDRESS_BITS-1:0] mag_raw;

  assign neg_raw = line < prev_line;
  assign diff_up = line - prev_line;
  assign diff_dn = prev_line - line;
  assign mag_raw = neg_raw ? diff_dn : diff_up;

  always_comb begin
    info.neg = neg_raw;
    mag      = mag_raw;
    if (!history_valid) begin
      // first read: load history with a zero stride
      info.cls = CL_RANDOM;
      info.neg = 1'b0;
      mag      = '0;
    end else if (mag_raw == '0) begin
      info.cls = CL_SAME;
    end else if (mag_raw == ADDRESS_BITS'(1)) begin
      if (prev_abs == ADDRESS_BITS'(1) && prev_neg == neg_raw) begin
        info.cls = CL_STREAM;
      end else begin
        info.cls = neg_raw ? CL_BACK : CL_NEXT;
      end
    end else begin
      info.cls = (mag_raw == prev_abs) ? CL_FIXED : CL_RANDOM;
    end
  end

endmodule

[sv/stride_pattern_mode_selector.sv]
`timescale 1ns / 1ps
// Stride pattern mode selector: classifies reads and re-chooses the prefetch mode.
//
//  channel | direction | handshake            | payload
//  s_*     | in        | s_tvalid / s_tready  | tdata: access_address; tuser: is_write
//  m_*     | out       | m_tvalid / m_tready  | tdata: prefetch_mode, mode_changed
//  cfg_*   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One access per cycle while the result is not stalled: an input register that forms the
// line number, then classify, count and decide into the result register.
// The classify-count-decide path is combinational, so accesses follow back to back.
// rst (synchronous) clears counters, history and mode (mode returns to stride).
// A stalled result holds; the input register keeps taking requests while
// the result register can be emptied in the same cycle.
module stride_pattern_mode_selector #(
  parameter int ADDRESS_BITS = spms_pkg::ADDRESS_BITS_DEF,
  parameter int COUNTER_BITS = spms_pkg::COUNTER_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((ADDRESS_BITS+7)/8)*8-1:0]        s_tdata,   // access_address
  input  logic [0:0]                               s_tuser,   // is_write
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [spms_pkg::OUT_TDATA_BITS-1:0]      m_tdata,   // prefetch_mode, mode_changed
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [spms_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [spms_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
  import spms_pkg::*;

  localparam int TOTAL_BITS   = COUNTER_BITS + 3;
  localparam int ORDERED_BITS = COUNTER_BITS + 2;
  localparam int PROD_BITS    = COUNTER_BITS + 6;
  localparam int CMP_BITS     = (COUNTER_BITS > WINDOW_BITS) ? COUNTER_BITS : WINDOW_BITS;

  // configuration
  logic [SHIFT_BITS-1:0]  line_size_log2;
  logic [WINDOW_BITS-1:0] window_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_size_log2 <= LINE_SIZE_LOG2_RESET;
      window_length  <= WINDOW_LENGTH_RESET;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_LINE_SIZE_LOG2: line_size_log2 <= cfg_data[SHIFT_BITS-1:0];
        REG_WINDOW_LENGTH:  window_length  <= cfg_data[WINDOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                    in_valid;
  logic [ADDRESS_BITS-1:0] in_line;
  logic                    in_write;
  logic                    advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_line  <= s_tdata[ADDRESS_BITS-1:0] >> line_size_log2;
      in_write <= s_tuser[0];
    end
  end

  // history and statistics
  logic                    history_valid;
  logic [ADDRESS_BITS-1:0] previous_line;
  logic                    previous_neg;
  logic [ADDRESS_BITS-1:0] previous_abs_stride;
  logic [COUNTER_BITS-1:0] class_count [NUM_CLASSES];
  logic [TOTAL_BITS-1:0]   total;
  logic [ORDERED_BITS-1:0] ordered;
  logic [COUNTER_BITS-1:0] window_count;
  mode_t                   current_mode;

  class_info_t             info;
  logic [ADDRESS_BITS-1:0] mag;

  spms_classify #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_classify (
    .line          (in_line),
    .prev_line     (previous_line),
    .prev_neg      (previous_neg),
    .prev_abs      (previous_abs_stride),
    .history_valid (history_valid),
    .info          (info),
    .mag           (mag)
  );

  logic                    counted;
  logic [NUM_CLASSES-1:0]  inc;
  logic [COUNTER_BITS-1:0] count_upd [NUM_CLASSES];
  logic [TOTAL_BITS-1:0]   total_upd;
  logic [ORDERED_BITS-1:0] ordered_upd;
  logic [COUNTER_BITS-1:0] window_upd;
  logic [PROD_BITS-1:0]    thr;
  logic [PROD_BITS-1:0]    random_x;
  logic [PROD_BITS-1:0]    same_x;
  logic [PROD_BITS-1:0]    ordered_x;
  logic                    decide;
  mode_t                   mode_new;
  mode_t                   mode_next;
  logic                    changed;

  always_comb begin
    counted = advance && !in_write;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      // saturate: drop the increment when the counter is full
      inc[i] = counted && (info.cls == class_t'(i)) && !(&class_count[i]);
      count_upd[i] = class_count[i] + COUNTER_BITS'(inc[i]);
    end
    total_upd   = total + TOTAL_BITS'(|inc);
    ordered_upd = ordered + ORDERED_BITS'(inc[CL_NEXT] | inc[CL_STREAM] |
                                          inc[CL_BACK] | inc[CL_FIXED]);
    window_upd  = window_count + COUNTER_BITS'(counted && !(&window_count));

    thr       = PROD_BITS'(total_upd) * PROD_BITS'(RATIO_NUM);
    random_x  = PROD_BITS'(count_upd[CL_RANDOM]) * PROD_BITS'(RATIO_DEN);
    same_x    = PROD_BITS'(count_upd[CL_SAME]) * PROD_BITS'(RATIO_DEN);
    ordered_x = PROD_BITS'(ordered_upd) * PROD_BITS'(RATIO_DEN);

    if (random_x > thr || same_x > thr) begin
      mode_new = MODE_DISABLED;
    end else if (ordered_x > thr) begin
      mode_new = MODE_STRIDE;
    end else begin
      mode_new = MODE_TAGGED;
    end

    // an empty window decides nothing
    decide    = advance && (CMP_BITS'(window_upd) >= CMP_BITS'(window_length)) &&
                (total_upd != '0);
    mode_next = decide ? mode_new : current_mode;
    changed   = mode_next != current_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_valid <= 1'b0;
      previous_neg  <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_count[i] <= '0;
      end
      total        <= '0;
      ordered      <= '0;
      window_count <= '0;
      current_mode <= MODE_STRIDE;
    end else if (advance) begin
      if (counted) begin
        history_valid <= 1'b1;
        previous_neg  <= info.neg;
      end
      if (decide) begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
          class_count[i] <= '0;
        end
        total        <= '0;
        ordered      <= '0;
        window_count <= '0;
      end else begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
          class_count[i] <= count_upd[i];
        end
        total        <= total_upd;
        ordered      <= ordered_upd;
        window_count <= window_upd;
      end
      current_mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (counted) begin
      previous_line       <= in_line;
      previous_abs_stride <= mag;
    end
  end

  // result register
  mode_t out_mode;
  logic  out_changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode    <= mode_next;
      out_changed <= changed;
    end
  end

  assign m_tdata = {(OUT_TDATA_BITS-MODE_BITS-1)'(0), out_changed, out_mode};

endmodule

[sv/spms_checker.sv]
`timescale 1ns / 1ps
// Port checker for the stride pattern mode selector, with its bind.
module spms_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [spms_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
  import spms_pkg::*;

  logic [MODE_BITS-1:0] last_mode;

  // track the mode of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode <= MODE_STRIDE;
    end else if (m_tvalid && m_tready) begin
      last_mode <= m_tdata[MODE_BITS-1:0];
    end
  end

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[MODE_BITS-1:0] == MODE_DISABLED ||
                  m_tdata[MODE_BITS-1:0] == MODE_STRIDE ||
                  m_tdata[MODE_BITS-1:0] == MODE_TAGGED))
    else $error("illegal prefetch mode");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |->
      (m_tdata[OUT_CHANGED_BIT] == (m_tdata[MODE_BITS-1:0] != last_mode)))
    else $error("mode_changed disagrees with mode sequence");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result not held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind stride_pattern_mode_selector spms_checker u_spms_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
